FILE: sv/ssu_pkg.sv
// ----------------------------------------------------------------------------
// ssu_pkg
// Types, constants and arithmetic helpers of the selective scan state update.
// ----------------------------------------------------------------------------
`default_nettype none

package ssu_pkg;

    // Default geometry
    localparam int DEF_CHANNELS   = 64;
    localparam int DEF_STATE_SIZE = 16;

    // State entry width and configuration port
    localparam int STATE_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DTX_SHIFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_SHIFT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B_SHIFT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SHIFT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_SHIFT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAC_BITS_A = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_MAX   = 3'd6;

    // Register reset values
    localparam logic signed [5:0] RST_SHIFT       = 6'sd0;
    localparam logic [3:0]        RST_FRAC_BITS_A = 4'd15;
    localparam logic [14:0]       RST_DECAY_MAX   = 15'd32735;

    // Saturation limits of a 16-bit result
    localparam logic signed [31:0] SAT_MAX = 32'sd32767;
    localparam logic signed [31:0] SAT_MIN = -32'sd32768;

    typedef struct packed {
        logic [5:0]         channel;
        logic [3:0]         state_index;
        logic               first_step;
        logic signed [15:0] step_size;
        logic signed [15:0] norm_input;
        logic signed [15:0] decay_coef;
        logic signed [15:0] b_coef;
        logic signed [15:0] c_coef;
        logic signed [7:0]  skip_weight;
    } t_in_item;

    typedef struct packed {
        logic [5:0]         out_channel;
        logic signed [15:0] y_value;
    } t_out_item;

    // Round-half-up arithmetic shift on a 32-bit pattern; negative s shifts left
    function automatic logic [31:0] f_rshift_rnd(input logic [31:0] v,
                                                 input logic signed [5:0] s);
        logic [5:0]  n;
        logic [4:0]  r;
        logic [31:0] t;
        logic [31:0] res;
        n = 6'(-s);
        r = s[4:0];
        t = v + (32'd1 << 5'(r - 5'd1));
        if (s == 6'sd0) begin
            res = v;
        end else if (s[5]) begin
            res = n[5] ? 32'd0 : (v << n[4:0]);
        end else begin
            res = 32'($signed(t) >>> r);
        end
        return res;
    endfunction

    // Saturate a 32-bit signed value to 16 bits
    function automatic logic signed [15:0] f_sat16(input logic [31:0] v);
        logic signed [15:0] res;
        if ($signed(v) > SAT_MAX) begin
            res = 16'sh7FFF;
        end else if ($signed(v) < SAT_MIN) begin
            res = 16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: sv/selective_scan_state_update_top.sv
// ----------------------------------------------------------------------------
// selective_scan_state_update_top
// Integer selective state-space scan: per item, update one int16 state entry
// in RAM and accumulate state times C; emit y on the last state index.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the output is not stalled; an item that
//   hits the same state entry as the item just before it is held back behind a
//   bubble (RAM read plus the state multiply). Reset: synchronous, active low;
//   then a clearing pass over every state entry zeroes the state RAM with the input stalled; config is taken.
`default_nettype none

module selective_scan_state_update_top
    import ssu_pkg::*;
#(
    parameter int CHANNELS   = DEF_CHANNELS,
    parameter int STATE_SIZE = DEF_STATE_SIZE
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input items
    input  wire logic                  i_in_valid,
    input  wire t_in_item              i_in_item,
    output logic                       o_in_stall,
    // result items
    output logic                       o_out_valid,
    output t_out_item                  o_out_item,
    input  wire logic                  i_out_stall,
    // configuration
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DEPTH = CHANNELS * STATE_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int LG    = $clog2(STATE_SIZE + 1) - 1;
    localparam int SP    = (LG > 1) ? LG - 1 : 0;
    localparam logic signed [5:0] SUM_SHIFT = 6'(SP);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [5:0] r_dtx_shift, r_decay_shift, r_b_shift, r_y_shift, r_skip_shift;
    logic [3:0]        r_frac_bits_a;
    logic [14:0]       r_decay_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dtx_shift   <= RST_SHIFT;
            r_decay_shift <= RST_SHIFT;
            r_b_shift     <= RST_SHIFT;
            r_y_shift     <= RST_SHIFT;
            r_skip_shift  <= RST_SHIFT;
            r_frac_bits_a <= RST_FRAC_BITS_A;
            r_decay_max   <= RST_DECAY_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DTX_SHIFT:   r_dtx_shift   <= i_cfg_data[5:0];
                CFG_DECAY_SHIFT: r_decay_shift <= i_cfg_data[5:0];
                CFG_B_SHIFT:     r_b_shift     <= i_cfg_data[5:0];
                CFG_Y_SHIFT:     r_y_shift     <= i_cfg_data[5:0];
                CFG_SKIP_SHIFT:  r_skip_shift  <= i_cfg_data[5:0];
                CFG_FRAC_BITS_A: r_frac_bits_a <= i_cfg_data[3:0];
                CFG_DECAY_MAX:   r_decay_max   <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;
    logic          r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic          r_out_valid;
    logic [AW-1:0] r_pos1, r_pos2, r_pos3, r_pos4;

    logic w_adv, w_hazard, w_front_adv, w_accept, w_in_range;
    logic [AW-1:0] w_pos_in;

    // Hold everything while a finished result waits
    assign w_adv       = !(r_out_valid && i_out_stall);
    // Same entry back to back: hold stage 1 and send a bubble to stage 2
    assign w_hazard    = r_v1 && r_v2 && (r_pos1 == r_pos2);
    assign w_front_adv = w_adv && !w_hazard;
    assign o_in_stall  = r_clr_busy || !w_front_adv;
    assign w_accept    = i_in_valid && !o_in_stall;

    assign w_in_range = (32'(i_in_item.channel) < 32'(CHANNELS))
                     && (32'(i_in_item.state_index) < 32'(STATE_SIZE));
    assign w_pos_in   = AW'(32'(i_in_item.channel) * 32'(STATE_SIZE)
                          + 32'(i_in_item.state_index));

    // ------------------------------------------------------------------
    // Stage 1: input products, RAM read issued at accept
    // ------------------------------------------------------------------
    logic [5:0]         r_chan1, r_chan2, r_chan3, r_chan4, r_chan5, r_chan6;
    logic               r_idx0_1, r_idx0_2, r_idx0_3, r_idx0_4, r_idx0_5;
    logic               r_last1, r_last2, r_last3, r_last4, r_last5;
    logic               r_first1;
    logic signed [31:0] r_p_dtx1, r_p_dta1;
    logic signed [31:0] r_p_skip1, r_p_skip2, r_p_skip3, r_p_skip4, r_p_skip5, r_p_skip6;
    logic signed [15:0] r_b1, r_b2;
    logic signed [15:0] r_c1, r_c2, r_c3, r_c4;

    logic signed [31:0] w_dt32, w_x32, w_a32, w_d32;

    assign w_dt32 = 32'(i_in_item.step_size);
    assign w_x32  = 32'(i_in_item.norm_input);
    assign w_a32  = 32'(i_in_item.decay_coef);
    assign w_d32  = 32'(i_in_item.skip_weight);

    // RAM
    logic                 w_ram_we;
    logic [AW-1:0]        w_ram_waddr, w_ram_raddr;
    logic [STATE_W-1:0]   w_ram_wdata, w_ram_rdata;
    logic signed [15:0]   w_h3;

    // Re-read the held entry every cycle so stage 1 sees all retired writes
    assign w_ram_raddr = w_front_adv ? w_pos_in : r_pos1;
    assign w_ram_we    = r_clr_busy || (w_adv && r_v3);
    assign w_ram_waddr = r_clr_busy ? r_clr_addr : r_pos3;
    assign w_ram_wdata = r_clr_busy ? '0 : w_h3;

    ssu_ram #(
        .WIDTH (STATE_W),
        .DEPTH (DEPTH)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 1 -> 2: dtx, decay factor, old state with forwarding
    // ------------------------------------------------------------------
    logic signed [15:0] w_dtx1, w_old1;
    logic [31:0]        w_dta1, w_araw1;
    logic [14:0]        w_a1;
    logic signed [15:0] r_h4;

    assign w_dtx1 = f_sat16(f_rshift_rnd(r_p_dtx1, r_dtx_shift));
    assign w_dta1 = f_rshift_rnd(r_p_dta1, r_decay_shift);
    assign w_araw1 = (32'd1 << r_frac_bits_a) - w_dta1;

    always_comb begin
        if ($signed(w_araw1) < 32'sd0) begin
            w_a1 = '0;
        end else if ($signed(w_araw1) > $signed({17'd0, r_decay_max})) begin
            w_a1 = r_decay_max;
        end else begin
            w_a1 = w_araw1[14:0];
        end
    end

    always_comb begin
        if (r_first1) begin
            w_old1 = '0;
        end else if (r_v3 && (r_pos3 == r_pos1)) begin
            w_old1 = w_h3;
        end else if (r_v4 && (r_pos4 == r_pos1)) begin
            w_old1 = r_h4;
        end else begin
            w_old1 = $signed(w_ram_rdata);
        end
    end

    logic signed [15:0] r_dtx2, r_old2;
    logic [14:0]        r_a2;

    // ------------------------------------------------------------------
    // Stage 2 -> 3: input term and decayed state products
    // Stage 3 -> 4: new state, written back
    // ------------------------------------------------------------------
    logic signed [31:0] r_p_bb3, r_p_ah3;

    assign w_h3 = f_sat16(f_rshift_rnd(r_p_ah3, $signed({2'b00, r_frac_bits_a}))
                          + f_rshift_rnd(r_p_bb3, r_b_shift));

    // ------------------------------------------------------------------
    // Stage 4 -> 5: state times C; stage 5: accumulate
    // ------------------------------------------------------------------
    logic signed [31:0] r_p_hc5;
    logic [31:0]        r_acc, w_acc_sum, r_acc6;

    assign w_acc_sum = (r_idx0_5 ? 32'd0 : r_acc) + f_rshift_rnd(r_p_hc5, SUM_SHIFT);

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_v6        <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc       <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= AW'(r_clr_addr + 1'b1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (w_front_adv) begin
                r_v1 <= w_accept && w_in_range;
            end
            if (w_adv) begin
                r_v2        <= r_v1 && !w_hazard;
                r_v3        <= r_v2;
                r_v4        <= r_v3;
                r_v5        <= r_v4;
                r_v6        <= r_v5 && r_last5;
                r_out_valid <= r_v6;
                if (r_v5) begin
                    // drop the sum once it has been passed on for output
                    r_acc <= r_last5 ? 32'd0 : w_acc_sum;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    t_out_item r_out_item;

    always_ff @(posedge i_clk) begin
        if (w_front_adv) begin
            r_pos1    <= w_pos_in;
            r_chan1   <= i_in_item.channel;
            r_idx0_1  <= (i_in_item.state_index == 4'd0);
            r_last1   <= (32'(i_in_item.state_index) == 32'(STATE_SIZE - 1));
            r_first1  <= i_in_item.first_step;
            r_p_dtx1  <= w_dt32 * w_x32;
            r_p_dta1  <= w_dt32 * w_a32;
            r_p_skip1 <= w_d32 * w_x32;
            r_b1      <= i_in_item.b_coef;
            r_c1      <= i_in_item.c_coef;
        end
        if (w_adv) begin
            r_pos2    <= r_pos1;
            r_chan2   <= r_chan1;
            r_idx0_2  <= r_idx0_1;
            r_last2   <= r_last1;
            r_p_skip2 <= r_p_skip1;
            r_b2      <= r_b1;
            r_c2      <= r_c1;
            r_dtx2    <= w_dtx1;
            r_a2      <= w_a1;
            r_old2    <= w_old1;

            r_pos3    <= r_pos2;
            r_chan3   <= r_chan2;
            r_idx0_3  <= r_idx0_2;
            r_last3   <= r_last2;
            r_p_skip3 <= r_p_skip2;
            r_c3      <= r_c2;
            r_p_bb3   <= 32'(r_dtx2) * 32'(r_b2);
            r_p_ah3   <= $signed({17'd0, r_a2}) * 32'(r_old2);

            r_pos4    <= r_pos3;
            r_chan4   <= r_chan3;
            r_idx0_4  <= r_idx0_3;
            r_last4   <= r_last3;
            r_p_skip4 <= r_p_skip3;
            r_c4      <= r_c3;
            r_h4      <= w_h3;

            r_chan5   <= r_chan4;
            r_idx0_5  <= r_idx0_4;
            r_last5   <= r_last4;
            r_p_skip5 <= r_p_skip4;
            r_p_hc5   <= 32'(r_h4) * 32'(r_c4);

            r_chan6   <= r_chan5;
            r_p_skip6 <= r_p_skip5;
            r_acc6    <= w_acc_sum;

            r_out_item.out_channel <= r_chan6;
            r_out_item.y_value     <= f_sat16(f_rshift_rnd(r_acc6, r_y_shift)
                                              + f_rshift_rnd(r_p_skip6, r_skip_shift));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_hazard_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_hazard && w_adv) |=> !r_v2)
        else $error("same-entry items entered stage 2 back to back");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (!r_v1 && !r_v3 && !r_out_valid))
        else $error("item in flight during state clearing");

    a_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_v5 && r_last5) |=> (r_acc == 32'd0))
        else $error("accumulator not cleared after emission");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_v6))
        else $error("result without a last-index item");

endmodule

`default_nettype wire

FILE: sv/ssu_ram.sv
// ----------------------------------------------------------------------------
// ssu_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ssu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read-first: a read and a write of the same entry return the old data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
